// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Both expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define RPDP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define RPDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RPDP_ASSERT_IMP(lbl, ante, cons, msg)
`define RPDP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/rpdp_pkg.sv
package rpdp_pkg;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] page_byte;
		logic [2:0] page_index;
		logic [6:0] column_index;
		logic       run_end;
		logic       frame_end;
	} out_item_t;

	typedef enum logic [1:0] {
		MODE_PACKED    = 2'd0,
		MODE_THRESHOLD = 2'd1,
		MODE_DITHER    = 2'd2
	} mode_t;

	localparam int ERR_W  = 12;
	localparam int SUM_W  = 14;
	localparam int PROD_W = 16;
	localparam int PAGE_W = 7;

	localparam logic signed [SUM_W-1:0] LIT_LEVEL  = 14'sd128;
	localparam logic signed [SUM_W-1:0] FULL_LEVEL = 14'sd255;

	typedef logic signed [ERR_W-1:0] err_t;

	localparam err_t ERR_MAX = 12'sh7ff;
	localparam err_t ERR_MIN = 12'sh800;

	// Error carried between neighbouring pixels of the dither.
	typedef struct packed {
		err_t right;
		err_t pend0;
		err_t pend1;
	} dith_state_t;

	typedef struct packed {
		logic lit;
		err_t left;
		err_t down;
		err_t down_right;
		err_t right;
	} dith_res_t;

	function automatic err_t sat_err(input logic signed [ERR_W:0] v);
		if (v > 13'sh07ff) begin
			return ERR_MAX;
		end else if (v < 13'sh1800) begin
			return ERR_MIN;
		end
		return v[ERR_W-1:0];
	endfunction

	// Division by sixteen that truncates toward zero.
	function automatic err_t div16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + (v[PROD_W-1] ? 16'sd15 : 16'sd0);
		return t[PROD_W-1:4];
	endfunction

endpackage

// File: rtl/rpdp_ram.sv
module rpdp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/rpdp_dither.sv
module rpdp_dither (
	input  logic                  [7:0] pixel,
	input  rpdp_pkg::err_t              line_err,
	input  rpdp_pkg::dith_state_t       st,
	output rpdp_pkg::dith_res_t         res
);

	import rpdp_pkg::*;

	logic signed [SUM_W-1:0]  old_v;
	logic signed [SUM_W-1:0]  err_v;
	logic signed [PROD_W-1:0] e16;
	logic signed [PROD_W-1:0] m7;
	logic signed [PROD_W-1:0] m3;
	logic signed [PROD_W-1:0] m5;
	err_t                     d3;
	err_t                     d5;

	always_comb begin
		old_v = $signed({6'b0, pixel}) + $signed({{2{line_err[ERR_W-1]}}, line_err})
			+ $signed({{2{st.right[ERR_W-1]}}, st.right});
		res.lit = old_v >= LIT_LEVEL;
		err_v = res.lit ? old_v - FULL_LEVEL : old_v;
		e16 = {{2{err_v[SUM_W-1]}}, err_v};
		m7 = (e16 <<< 3) - e16;
		m3 = (e16 <<< 1) + e16;
		m5 = (e16 <<< 2) + e16;
		d3 = div16(m3);
		d5 = div16(m5);
		// The partial sums for the row below pick up this pixel's shares.
		res.left = sat_err({st.pend0[ERR_W-1], st.pend0} + {d3[ERR_W-1], d3});
		res.down = sat_err({st.pend1[ERR_W-1], st.pend1} + {d5[ERR_W-1], d5});
		res.down_right = div16(e16);
		res.right = div16(m7);
	end

endmodule

// File: rtl/raster_to_page_dither_packer_top.sv
// Channel  Direction  Payload                       Handshake
// in       input      in_item_t (pixel, frame start) in_valid / in_ready
// out      output     out_item_t (one column byte)   out_valid / out_ready
// cfg      input      pixel_mode, 2 bits             cfg_valid / cfg_ready
//
// Modes 1 and 2 take one request per cycle while the output does not stall; each
// passes an input stage and then a result register on its way to the output.
// Mode 0 takes no new request until its packed byte is done: the up to eight
// columns of the byte go one at a time through the read-modify-write of the page store.
// Reset clears counters, error state and valid bits at once; no sweep is needed.
// A stalled output holds the single processing stage, and with it the input.
`include "assert_macros.svh"

module raster_to_page_dither_packer_top #(
	parameter int WIDTH_PIXELS  = 128,
	parameter int HEIGHT_PIXELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rpdp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rpdp_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_data
);

	import rpdp_pkg::*;

	localparam int CW    = $clog2(WIDTH_PIXELS);
	localparam int PAGES = (HEIGHT_PIXELS + 7) / 8;
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

	localparam logic [CW-1:0] LAST_COL  = CW'(WIDTH_PIXELS - 1);
	localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(WIDTH_PIXELS);
	localparam logic [PW-1:0] LAST_PAGE = PW'((HEIGHT_PIXELS - 1) / 8);
	localparam logic [2:0]    LAST_RIP  = 3'((HEIGHT_PIXELS - 1) % 8);
	localparam logic [2:0]    TOP_RIP   = 3'd7;

	typedef struct packed {
		logic [CW-1:0] col;
		logic [2:0]    rip;
		logic [PW-1:0] page;
		logic [7:0]    pix;
		logic          pre_lit;
		logic          dith;
		logic          emit;
		logic          last;
		logic          last_row;
		logic          frame_end;
	} op_t;

	logic [1:0]          pixel_mode_q;
	logic [CW-1:0]       col_q;
	logic [2:0]          rip_q;
	logic [PW-1:0]       page_q;
	logic                wrap_clr_q;

	logic                m0_q;
	logic [2:0]          m0_idx_q;
	logic [7:0]          m0_byte_q;
	logic [CW-1:0]       m0_col_q;
	logic [2:0]          m0_rip_q;
	logic [PW-1:0]       m0_page_q;

	op_t                 op_s1;
	logic                vld_s1;
	logic                line_vld_s1;

	err_t                right_q;
	err_t                pend0_q;
	err_t                pend1_q;
	err_t                tail_err_q;
	logic                tail_vld_q;
	logic [WIDTH_PIXELS-1:0] line_vld_q;

	out_item_t           out_q;
	logic                out_vld_q;

	logic                in_accept;
	logic                fs;
	logic                clr;
	logic [CW-1:0]       base_col;
	logic [2:0]          base_rip;
	logic [PW-1:0]       base_page;
	logic                base_last_row;
	logic                in_m0;
	logic [CW:0]         ncol;
	logic                row_wrap;
	logic                m0_last;
	logic                m0_last_row;
	op_t                 in_op;
	op_t                 m0_op;
	op_t                 new_op;
	logic                issue;
	logic                adv;
	logic                out_free;
	logic                s1_fire;

	logic [PAGE_W-1:0]   page_rdata;
	logic [PAGE_W-1:0]   page_new;
	err_t                err_rdata;
	err_t                line_err;
	dith_state_t         dst;
	dith_res_t           dres;
	logic                lit;
	logic                err_we;
	logic [CW-1:0]       err_waddr;

	assign fs        = in_data.frame_start;
	assign in_m0     = pixel_mode_q == MODE_PACKED;
	assign out_free  = !out_vld_q || out_ready;
	assign s1_fire   = vld_s1 && (!op_s1.emit || out_free);
	assign adv       = !vld_s1 || s1_fire;
	assign in_ready  = adv && !m0_q;
	assign in_accept = in_valid && in_ready;
	assign issue     = adv && (m0_q || in_valid);
	assign clr       = in_accept && (fs || wrap_clr_q);
	assign cfg_ready = 1'b1;

	always_comb begin
		base_col  = fs ? '0 : col_q;
		base_rip  = fs ? '0 : rip_q;
		base_page = fs ? '0 : page_q;
		base_last_row = (base_page == LAST_PAGE) && (base_rip == LAST_RIP);
		ncol = {1'b0, base_col} + (in_m0 ? (CW + 1)'(8) : (CW + 1)'(1));
		row_wrap = ncol >= COL_LIMIT;

		in_op.col       = base_col;
		in_op.rip       = base_rip;
		in_op.page      = base_page;
		in_op.pix       = in_data.pixel_byte;
		// The leftmost packed pixel and the threshold bit are the same bit.
		in_op.pre_lit   = in_data.pixel_byte[7];
		in_op.dith      = pixel_mode_q == MODE_DITHER;
		in_op.emit      = (base_rip == TOP_RIP) || base_last_row;
		in_op.last      = !in_m0 || (base_col == LAST_COL);
		in_op.last_row  = base_last_row;
		in_op.frame_end = base_last_row && (base_col == LAST_COL);

		m0_last_row = (m0_page_q == LAST_PAGE) && (m0_rip_q == LAST_RIP);
		m0_last     = (m0_idx_q == 3'd7) || (m0_col_q == LAST_COL);
		m0_op.col       = m0_col_q;
		m0_op.rip       = m0_rip_q;
		m0_op.page      = m0_page_q;
		m0_op.pix       = m0_byte_q;
		m0_op.pre_lit   = m0_byte_q[7];
		m0_op.dith      = 1'b0;
		m0_op.emit      = (m0_rip_q == TOP_RIP) || m0_last_row;
		m0_op.last      = m0_last;
		m0_op.last_row  = m0_last_row;
		m0_op.frame_end = m0_last_row && (m0_col_q == LAST_COL);

		new_op = m0_q ? m0_op : in_op;
	end

	// The last column's carried error lives in a register, so the row end can
	// update two entries in the same cycle.
	always_comb begin
		if (op_s1.col == LAST_COL) begin
			line_err = tail_vld_q ? tail_err_q : '0;
		end else begin
			line_err = line_vld_s1 ? err_rdata : '0;
		end
		dst.right = right_q;
		dst.pend0 = pend0_q;
		dst.pend1 = pend1_q;
	end

	rpdp_dither u_dither (
		.pixel    (op_s1.pix),
		.line_err (line_err),
		.st       (dst),
		.res      (dres)
	);

	always_comb begin
		lit = op_s1.dith ? dres.lit : op_s1.pre_lit;
		page_new = (op_s1.rip == 3'd0) ? '0 : page_rdata;
		if (op_s1.rip != TOP_RIP) begin
			page_new = page_new | (PAGE_W'(lit) << op_s1.rip);
		end
		err_we = s1_fire && op_s1.dith && !op_s1.last_row && (op_s1.col != '0);
		err_waddr = op_s1.col - CW'(1);
	end

	rpdp_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (WIDTH_PIXELS)
	) u_page_ram (
		.clk   (clk),
		.we    (s1_fire),
		.waddr (op_s1.col),
		.wdata (page_new),
		.re    (issue),
		.raddr (new_op.col),
		.rdata (page_rdata)
	);

	rpdp_ram #(
		.WIDTH (ERR_W),
		.DEPTH (WIDTH_PIXELS)
	) u_err_ram (
		.clk   (clk),
		.we    (err_we),
		.waddr (err_waddr),
		.wdata (dres.left),
		.re    (issue),
		.raddr (new_op.col),
		.rdata (err_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= MODE_THRESHOLD;
		end else if (cfg_valid && cfg_ready) begin
			pixel_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			rip_q      <= '0;
			page_q     <= '0;
			wrap_clr_q <= 1'b0;
		end else if (in_accept) begin
			if (row_wrap) begin
				col_q      <= '0;
				wrap_clr_q <= base_last_row;
				if (base_last_row) begin
					rip_q  <= '0;
					page_q <= '0;
				end else if (base_rip == TOP_RIP) begin
					rip_q  <= '0;
					page_q <= base_page + PW'(1);
				end else begin
					rip_q  <= base_rip + 3'd1;
					page_q <= base_page;
				end
			end else begin
				col_q      <= ncol[CW-1:0];
				rip_q      <= base_rip;
				page_q     <= base_page;
				wrap_clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_q <= 1'b0;
		end else if (in_accept && in_m0 && (base_col != LAST_COL)) begin
			m0_q <= 1'b1;
		end else if (m0_q && issue && m0_last) begin
			m0_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && in_m0) begin
			m0_idx_q  <= 3'd1;
			m0_col_q  <= base_col + CW'(1);
			m0_byte_q <= in_data.pixel_byte << 1;
			m0_rip_q  <= base_rip;
			m0_page_q <= base_page;
		end else if (m0_q && issue) begin
			m0_idx_q  <= m0_idx_q + 3'd1;
			m0_col_q  <= m0_col_q + CW'(1);
			m0_byte_q <= m0_byte_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1       <= new_op;
			line_vld_s1 <= !clr && line_vld_q[new_op.col];
		end
	end

	// A clear from a new frame wins over a write from the item ahead of it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q <= '0;
		end else if (clr) begin
			line_vld_q <= '0;
		end else if (err_we) begin
			line_vld_q[err_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q    <= '0;
			pend0_q    <= '0;
			pend1_q    <= '0;
			tail_vld_q <= 1'b0;
		end else if (clr) begin
			right_q    <= '0;
			pend0_q    <= '0;
			pend1_q    <= '0;
			tail_vld_q <= 1'b0;
		end else if (s1_fire && op_s1.dith) begin
			if (op_s1.col == LAST_COL) begin
				right_q <= '0;
				pend0_q <= '0;
				pend1_q <= '0;
				if (!op_s1.last_row) begin
					tail_vld_q <= 1'b1;
				end
			end else begin
				right_q <= dres.right;
				pend0_q <= dres.down;
				pend1_q <= dres.down_right;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && op_s1.dith && (op_s1.col == LAST_COL) && !op_s1.last_row) begin
			tail_err_q <= dres.down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_fire && op_s1.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && op_s1.emit) begin
			out_q.page_byte    <= {lit && (op_s1.rip == TOP_RIP), page_new};
			out_q.page_index   <= 3'(op_s1.page);
			out_q.column_index <= 7'(op_s1.col);
			out_q.run_end      <= op_s1.last;
			out_q.frame_end    <= op_s1.frame_end;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`RPDP_ASSERT_IMP(a_frame_end_closes, out_valid && out_data.frame_end, out_data.run_end, "frame end byte is not the last of its request")
	`RPDP_ASSERT_NEXT(a_frame_start_clears, in_accept && in_data.frame_start, (line_vld_q == '0) && (right_q == '0) && (pend0_q == '0) && (pend1_q == '0) && !tail_vld_q, "error state not cleared by frame start")
	`RPDP_ASSERT_IMP(a_page_in_range, out_valid, out_data.page_index <= 3'(LAST_PAGE), "page index beyond the last page")
	`RPDP_ASSERT_IMP(a_frame_end_emits, vld_s1 && op_s1.frame_end, op_s1.emit && op_s1.last, "frame end column not emitted as last byte")

endmodule
